// ===== design/cas_pkg.sv =====
// ----------------------------------------------------------------------------
// cas_pkg: shared types and constants of the claw actuator sequencer
// operation codes, routine kinds, register indexes, actuator and revolver
// state records, reset values of the configuration registers
// ----------------------------------------------------------------------------
package cas_pkg;

	// operation codes carried in tuser
	localparam logic [1:0] OP_TICK         = 2'd0;
	localparam logic [1:0] OP_LOAD_ROUTINE = 2'd1;
	localparam logic [1:0] OP_LOAD_REV     = 2'd2;

	// routine kinds
	localparam logic [3:0] RT_LOWER      = 4'd1;
	localparam logic [3:0] RT_EDGE_LOWER = 4'd2;
	localparam logic [3:0] RT_GRIP       = 4'd3;
	localparam logic [3:0] RT_RELEASE    = 4'd4;
	localparam logic [3:0] RT_RAISE      = 4'd5;
	localparam logic [3:0] RT_EDGE_RAISE = 4'd6;

	// configuration register indexes
	localparam logic [2:0] REG_EDGE_DOWN_TIME        = 3'd0;
	localparam logic [2:0] REG_EDGE_DOWN_ROTATE_TIME = 3'd1;
	localparam logic [2:0] REG_EDGE_UP_TIME          = 3'd2;
	localparam logic [2:0] REG_EDGE_UP_ROTATE_TIME   = 3'd3;
	localparam logic [2:0] REG_REVOLVER_DEBOUNCE     = 3'd4;
	localparam logic [2:0] REG_CLAW_SPEED            = 3'd5;
	localparam logic [2:0] REG_REVOLVER_SPEED        = 3'd6;
	localparam logic [2:0] REG_HOLD_MASK             = 3'd7;

	// reset values of the registers that are kept
	localparam logic [15:0] RST_EDGE_DOWN_TIME        = 16'd500;
	localparam logic [15:0] RST_EDGE_DOWN_ROTATE_TIME = 16'd1000;
	localparam logic [15:0] RST_EDGE_UP_TIME          = 16'd300;
	localparam logic [15:0] RST_EDGE_UP_ROTATE_TIME   = 16'd600;
	localparam logic [15:0] RST_REVOLVER_DEBOUNCE     = 16'd250;
	localparam logic [2:0]  RST_HOLD_MASK             = 3'd0;

	// actuator slots
	localparam int ACT_N     = 3;
	localparam int ACT_LIFT  = 0;
	localparam int ACT_ROT   = 1;
	localparam int ACT_CLAMP = 2;

	// drive codes from the routine: bit1 on, bit0 direction
	localparam logic [1:0] DRV_OFF     = 2'b00;
	localparam logic [1:0] DRV_ON_LOW  = 2'b10;
	localparam logic [1:0] DRV_ON_HIGH = 2'b11;

	// one actuator: on, direction, latched high-end and low-end switches
	typedef struct packed {
		logic on;
		logic dir;
		logic hi;
		logic lo;
	} act_t;

	// routine request toward the actuators
	typedef struct packed {
		logic       set;
		logic [1:0] lift;
		logic [1:0] rot;
		logic [1:0] clamp;
	} rt_cmd_t;

	// revolver job status
	typedef struct packed {
		logic       run;
		logic       btn;
		logic       dir;
		logic [3:0] cnt;
	} rv_t;

	// stage timing limits handed to the routine stepper
	typedef struct packed {
		logic [15:0] edge_down_time;
		logic [15:0] edge_down_rotate_time;
		logic [15:0] edge_up_time;
		logic [15:0] edge_up_rotate_time;
	} rt_limits_t;

endpackage

// ===== design/cas_routine.sv =====
// ----------------------------------------------------------------------------
// cas_routine: one step of the staged claw routine
// picks the next stage and the drive codes of lift, rotate and clamp
// ----------------------------------------------------------------------------
module cas_routine (
	input  logic [3:0]           kind,
	input  logic [3:0]           stage,
	input  logic [31:0]          elapsed,
	input  cas_pkg::rt_limits_t  limits,
	input  cas_pkg::act_t        lift,
	input  cas_pkg::act_t        rot,
	input  cas_pkg::act_t        clamp,
	output logic [3:0]           stage_next,
	output cas_pkg::rt_cmd_t     cmd
);
	import cas_pkg::*;

	function automatic rt_cmd_t drive(logic [1:0] l, logic [1:0] r, logic [1:0] c);
		rt_cmd_t v;
		v.set   = 1'b1;
		v.lift  = l;
		v.rot   = r;
		v.clamp = c;
		return v;
	endfunction

	logic over_edt, over_edrt, over_eut, over_eurt;

	assign over_edt  = elapsed > {16'd0, limits.edge_down_time};
	assign over_edrt = elapsed > {16'd0, limits.edge_down_rotate_time};
	assign over_eut  = elapsed > {16'd0, limits.edge_up_time};
	assign over_eurt = elapsed > {16'd0, limits.edge_up_rotate_time};

	always_comb begin
		stage_next = stage;
		cmd        = '0;
		if (stage != 4'd0) begin
			unique case (kind)
				RT_LOWER: begin
					if (lift.lo) begin
						stage_next = stage - 4'd1;
						cmd        = drive(DRV_OFF, DRV_OFF, DRV_OFF);
					end else begin
						cmd = drive(DRV_ON_LOW, DRV_OFF, DRV_OFF);
					end
				end
				RT_EDGE_LOWER: begin
					unique case (stage)
						4'd4: begin
							if (over_edt) stage_next = stage - 4'd1;
							else cmd = drive(DRV_ON_LOW, DRV_OFF, DRV_OFF);
						end
						4'd3: begin
							// reaching inverted early skips the straight rotate stage
							if (over_edrt) stage_next = stage - 4'd1;
							else if (rot.lo) stage_next = stage - 4'd2;
							else cmd = drive(DRV_ON_LOW, DRV_ON_LOW, DRV_OFF);
						end
						4'd2: begin
							if (rot.lo) stage_next = stage - 4'd1;
							else cmd = drive(DRV_OFF, DRV_ON_LOW, DRV_OFF);
						end
						4'd1: begin
							if (lift.lo) begin
								stage_next = stage - 4'd1;
								cmd        = drive(DRV_OFF, DRV_OFF, DRV_OFF);
							end else begin
								cmd = drive(DRV_ON_LOW, DRV_OFF, DRV_OFF);
							end
						end
						default: ;
					endcase
				end
				RT_GRIP: begin
					if (clamp.hi) begin
						stage_next = stage - 4'd1;
						cmd        = drive(DRV_OFF, DRV_OFF, DRV_OFF);
					end else begin
						cmd = drive(DRV_OFF, DRV_OFF, DRV_ON_HIGH);
					end
				end
				RT_RELEASE: begin
					if (clamp.lo) begin
						stage_next = stage - 4'd1;
						cmd        = drive(DRV_OFF, DRV_OFF, DRV_OFF);
					end else begin
						cmd = drive(DRV_OFF, DRV_OFF, DRV_ON_LOW);
					end
				end
				RT_RAISE: begin
					unique case (stage)
						4'd2: begin
							if (rot.hi || lift.hi) stage_next = stage - 4'd1;
							else cmd = drive(DRV_ON_HIGH, DRV_ON_HIGH, DRV_OFF);
						end
						4'd1: begin
							if (lift.hi) begin
								stage_next = stage - 4'd1;
								cmd        = drive(DRV_OFF, DRV_OFF, DRV_OFF);
							end else begin
								cmd = drive(DRV_ON_HIGH, DRV_OFF, DRV_OFF);
							end
						end
						default: ;
					endcase
				end
				RT_EDGE_RAISE: begin
					unique case (stage)
						4'd4: begin
							if (over_eut) stage_next = stage - 4'd1;
							else cmd = drive(DRV_ON_HIGH, DRV_OFF, DRV_OFF);
						end
						4'd3: begin
							if (over_eurt) stage_next = stage - 4'd1;
							else cmd = drive(DRV_ON_HIGH, DRV_ON_HIGH, DRV_OFF);
						end
						4'd2: begin
							if (rot.hi) stage_next = stage - 4'd1;
							else cmd = drive(DRV_OFF, DRV_ON_HIGH, DRV_OFF);
						end
						4'd1: begin
							if (lift.hi) begin
								stage_next = stage - 4'd1;
								cmd        = drive(DRV_OFF, DRV_OFF, DRV_OFF);
							end else begin
								cmd = drive(DRV_ON_HIGH, DRV_OFF, DRV_OFF);
							end
						end
						default: ;
					endcase
				end
				default: ;  // unknown kind stalls
			endcase
		end
	end

endmodule

// ===== design/cas_revolver.sv =====
// ----------------------------------------------------------------------------
// cas_revolver: one step of the revolver job
// runs the motor and counts debounced button presses down to zero
// ----------------------------------------------------------------------------
module cas_revolver (
	input  cas_pkg::rv_t  status,
	input  logic [31:0]   now_ms,
	input  logic [31:0]   last_press,
	input  logic [15:0]   debounce,
	input  logic [1:0]    motor,
	output cas_pkg::rv_t  status_next,
	output logic [31:0]   last_press_next,
	output logic [1:0]    motor_next
);
	import cas_pkg::*;

	logic [31:0] since_press;

	assign since_press = now_ms - last_press;

	always_comb begin
		status_next     = status;
		last_press_next = last_press;
		motor_next      = motor;
		if (status.run) begin
			if (status.cnt != 4'd0) begin
				motor_next = {status.dir, 1'b1};
				if (since_press > {16'd0, debounce} && status.btn) begin
					status_next.cnt = status.cnt - 4'd1;
					last_press_next = now_ms;
				end
			end else begin
				status_next.run = 1'b0;
				motor_next      = 2'b00;
			end
		end
	end

endmodule

// ===== design/cas_actuators.sv =====
// ----------------------------------------------------------------------------
// cas_actuators: end-switch stop and motor output mapping
// stops an actuator at the end switch in its direction, honors the hold mask
// ----------------------------------------------------------------------------
module cas_actuators (
	input  cas_pkg::act_t [cas_pkg::ACT_N-1:0]  act,
	input  logic [cas_pkg::ACT_N-1:0]           hold,
	input  logic [2*cas_pkg::ACT_N-1:0]         motor,
	output logic [cas_pkg::ACT_N-1:0]           on_next,
	output logic [cas_pkg::ACT_N-1:0]           dir_next,
	output logic [2*cas_pkg::ACT_N-1:0]         motor_next
);
	import cas_pkg::*;

	always_comb begin
		for (int i = 0; i < ACT_N; i++) begin
			dir_next[i] = act[i].dir;
			on_next[i]  = act[i].on &&
				!((act[i].dir && act[i].hi) || (!act[i].dir && act[i].lo));
			// slot: bit0 on, bit1 direction, zero when stopped
			if (hold[i]) motor_next[2*i +: 2] = motor[2*i +: 2];
			else motor_next[2*i +: 2] = {on_next[i] & act[i].dir, on_next[i]};
		end
	end

endmodule

// ===== design/claw_actuator_sequencer.sv =====
// ----------------------------------------------------------------------------
// claw_actuator_sequencer: claw routine and revolver motor controller
// one control tick per input beat, one status beat out per tick
// ----------------------------------------------------------------------------
// path: an accepted beat goes into the input register; its result loads into
//   the result register, and turns valid, once that register is free
// throughput: one beat per cycle unless m_tready stalls; the input and
//   result registers let a new beat in while a result still waits on m_tready
// reset: arst_n clears routine, revolver job, actuators and motor outputs and
//   loads the register defaults; no clearing pass, ready as soon as reset ends
// ----------------------------------------------------------------------------
module claw_actuator_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	// slave side
	input  logic        s_tvalid,
	output logic        s_tready,
	// from bit 0: now_ms[31:0], clamp_closed_sw, clamp_open_sw, rot_upright_sw,
	// rot_inverted_sw, lift_top_sw, lift_bottom_sw, revolver_sw, cmd_a[3:0],
	// cmd_b[3:0], one zero pad bit
	input  logic [47:0] s_tdata,
	// from bit 0: operation[1:0]
	input  logic [1:0]  s_tuser,
	// master side
	output logic        m_tvalid,
	input  logic        m_tready,
	// from bit 0: lift_on, lift_dir, rotate_on, rotate_dir, clamp_on, clamp_dir,
	// revolver_on, revolver_dir, routine_kind[3:0], routine_left[3:0],
	// revolver_left[3:0], four zero pad bits
	output logic [23:0] m_tdata,
	// configuration write port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);
	import cas_pkg::*;

	// configuration
	logic [15:0] edt_q, edrt_q, eut_q, eurt_q, debounce_q;
	logic [2:0]  hold_q;

	// block state
	logic [ACT_N-1:0] on_q, dir_q;
	logic [3:0]       kind_q, stage_q;
	logic [31:0]      start_q;
	rv_t              rv_q;
	logic [31:0]      last_press_q;
	logic [7:0]       motor_q;

	// input register
	logic        valid_s1;
	logic [47:0] data_s1;
	logic [1:0]  op_s1;

	// result register
	logic        valid_s2;
	logic [23:0] data_s2;

	logic advance;

	// beat fields out of the input register
	logic [31:0] now_ms;
	logic [3:0]  cmd_a, cmd_b;

	assign now_ms = data_s1[31:0];
	assign cmd_a  = data_s1[42:39];
	assign cmd_b  = data_s1[46:43];

	// command handling ahead of the tick
	logic [3:0]  kind_ld, stage_ld;
	logic [31:0] start_ld;
	rv_t         rv_ld;

	always_comb begin
		kind_ld  = kind_q;
		stage_ld = stage_q;
		start_ld = start_q;
		rv_ld    = rv_q;
		if (op_s1 == OP_LOAD_ROUTINE) begin
			kind_ld  = cmd_a;
			stage_ld = cmd_b;
			start_ld = now_ms;
		end else if (op_s1 == OP_LOAD_REV) begin
			rv_ld.run = 1'b1;
			rv_ld.dir = cmd_a[0];
			rv_ld.cnt = cmd_b;
		end
		// the button level is latched on every tick
		rv_ld.btn = data_s1[38];
	end

	// actuators with this beat's switch levels latched
	act_t [ACT_N-1:0] act_lat;

	always_comb begin
		for (int i = 0; i < ACT_N; i++) begin
			act_lat[i].on  = on_q[i];
			act_lat[i].dir = dir_q[i];
		end
		act_lat[ACT_CLAMP].hi = data_s1[32];
		act_lat[ACT_CLAMP].lo = data_s1[33];
		act_lat[ACT_ROT].hi   = data_s1[34];
		act_lat[ACT_ROT].lo   = data_s1[35];
		act_lat[ACT_LIFT].hi  = data_s1[36];
		act_lat[ACT_LIFT].lo  = data_s1[37];
	end

	// routine step
	rt_limits_t  limits;
	logic [31:0] elapsed;
	logic [3:0]  stage_nx;
	rt_cmd_t     rt_cmd;

	assign limits.edge_down_time        = edt_q;
	assign limits.edge_down_rotate_time = edrt_q;
	assign limits.edge_up_time          = eut_q;
	assign limits.edge_up_rotate_time   = eurt_q;
	assign elapsed = now_ms - start_ld;

	cas_routine u_routine (
		.kind       (kind_ld),
		.stage      (stage_ld),
		.elapsed    (elapsed),
		.limits     (limits),
		.lift       (act_lat[ACT_LIFT]),
		.rot        (act_lat[ACT_ROT]),
		.clamp      (act_lat[ACT_CLAMP]),
		.stage_next (stage_nx),
		.cmd        (rt_cmd)
	);

	// routine drive codes applied to the actuators
	act_t [ACT_N-1:0] act_drv;

	always_comb begin
		act_drv = act_lat;
		if (rt_cmd.set) begin
			{act_drv[ACT_LIFT].on, act_drv[ACT_LIFT].dir}   = rt_cmd.lift;
			{act_drv[ACT_ROT].on, act_drv[ACT_ROT].dir}     = rt_cmd.rot;
			{act_drv[ACT_CLAMP].on, act_drv[ACT_CLAMP].dir} = rt_cmd.clamp;
		end
	end

	// revolver step
	rv_t         rv_nx;
	logic [31:0] last_press_nx;
	logic [1:0]  rv_motor_nx;

	cas_revolver u_revolver (
		.status          (rv_ld),
		.now_ms          (now_ms),
		.last_press      (last_press_q),
		.debounce        (debounce_q),
		.motor           (motor_q[7:6]),
		.status_next     (rv_nx),
		.last_press_next (last_press_nx),
		.motor_next      (rv_motor_nx)
	);

	// end-switch stop and claw motor slots
	logic [ACT_N-1:0]   on_nx, dir_nx;
	logic [2*ACT_N-1:0] claw_motor_nx;

	cas_actuators u_actuators (
		.act        (act_drv),
		.hold       (hold_q),
		.motor      (motor_q[5:0]),
		.on_next    (on_nx),
		.dir_next   (dir_nx),
		.motor_next (claw_motor_nx)
	);

	// handshake: the input register moves on when the result register frees up
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = valid_s2;
	assign m_tdata  = data_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) valid_s1 <= 1'b1;
			else if (advance) valid_s1 <= 1'b0;
			if (advance) valid_s2 <= 1'b1;
			else if (m_tready) valid_s2 <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			data_s1 <= s_tdata;
			op_s1   <= s_tuser;
		end
		if (advance) begin
			data_s2 <= {4'd0, rv_nx.cnt, stage_nx, kind_ld, rv_motor_nx, claw_motor_nx};
		end
	end

	// state update, once per tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_q         <= '0;
			dir_q        <= '0;
			kind_q       <= '0;
			stage_q      <= '0;
			start_q      <= '0;
			rv_q         <= '0;
			last_press_q <= '0;
			motor_q      <= '0;
		end else if (advance) begin
			on_q         <= on_nx;
			dir_q        <= dir_nx;
			kind_q       <= kind_ld;
			stage_q      <= stage_nx;
			start_q      <= start_ld;
			rv_q         <= rv_nx;
			last_press_q <= last_press_nx;
			motor_q      <= {rv_motor_nx, claw_motor_nx};
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edt_q      <= RST_EDGE_DOWN_TIME;
			edrt_q     <= RST_EDGE_DOWN_ROTATE_TIME;
			eut_q      <= RST_EDGE_UP_TIME;
			eurt_q     <= RST_EDGE_UP_ROTATE_TIME;
			debounce_q <= RST_REVOLVER_DEBOUNCE;
			hold_q     <= RST_HOLD_MASK;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_EDGE_DOWN_TIME:        edt_q      <= cfg_wdata;
				REG_EDGE_DOWN_ROTATE_TIME: edrt_q     <= cfg_wdata;
				REG_EDGE_UP_TIME:          eut_q      <= cfg_wdata;
				REG_EDGE_UP_ROTATE_TIME:   eurt_q     <= cfg_wdata;
				REG_REVOLVER_DEBOUNCE:     debounce_q <= cfg_wdata;
				REG_CLAW_SPEED:            ;  // drive level applied downstream
				REG_REVOLVER_SPEED:        ;  // drive level applied downstream
				REG_HOLD_MASK:             hold_q     <= cfg_wdata[2:0];
				default:                   ;
			endcase
		end
	end

	// routine stages only count down unless a routine is loaded
	a_stage_down: assert property (@(posedge clk) disable iff (!arst_n)
		advance && op_s1 != OP_LOAD_ROUTINE |=> stage_q <= $past(stage_q))
		else $error("routine stage count went up without a load");

	// revolver steps only count down unless a job is loaded
	a_rev_down: assert property (@(posedge clk) disable iff (!arst_n)
		advance && op_s1 != OP_LOAD_REV |=> rv_q.cnt <= $past(rv_q.cnt))
		else $error("revolver step count went up without a load");

	// a held lift keeps its motor slot
	a_hold_lift: assert property (@(posedge clk) disable iff (!arst_n)
		advance && hold_q[ACT_LIFT] && !cfg_we |=> motor_q[1:0] == $past(motor_q[1:0]))
		else $error("held lift motor output changed");

	// the input side stalls only when both registers are full and blocked
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && valid_s2 && !m_tready)
		else $error("input stalled with room in the pipeline");

endmodule
